### src/flct_pkg.sv
package flct_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ID_W      = $clog2(MAX_NODES);
    // One code past the last node id stands for "no node"
    localparam int PTR_W     = $clog2(MAX_NODES + 1);
    localparam int LIMIT_W   = 11;
    localparam int CMP_W     = (ID_W > LIMIT_W) ? ID_W : LIMIT_W;
    localparam int KIND_W    = 3;

    localparam logic [PTR_W-1:0]   NONE_PTR    = PTR_W'(MAX_NODES);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
    localparam logic [ID_W-1:0]    LAST_ID     = ID_W'(MAX_NODES - 1);

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_START   = 3'd2,
        KIND_ADVANCE = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_LINK,
        ST_INS_NRD,
        ST_INS_W1,
        ST_INS_W2,
        ST_REM_RD,
        ST_REM_CHK,
        ST_ADV_RD,
        ST_ADV_MRD,
        ST_ADV_CHK,
        ST_CLR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic idle;
        logic rd_entry;
        logic rd_cur_next;
        logic rd_n_member;
        logic latch_entry;
        logic latch_next;
        logic unlink;
        logic mem_wr;
        logic mem_val;
        logic link_solo;
        logic link_w1;
        logic link_w2;
        logic cursor_head;
        logic cursor_next;
        logic cursor_none;
        logic clear_ptrs;
        logic sweep;
        logic set_err;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        kind_t kind;
        logic  in_range;
        logic  id_is_cursor;
        logic  cursor_node;
        logic  head_node;
        logic  head_after_err;
        logic  entry_member;
        logic  n_node;
        logic  n_member;
        logic  cnt_last;
        logic  out_free;
    } sts_t;

    function automatic logic is_node(input logic [PTR_W-1:0] p);
        return p < NONE_PTR;
    endfunction

    function automatic logic [PTR_W-1:0] to_ptr(input logic [ID_W-1:0] id);
        return PTR_W'(id);
    endfunction

endpackage

### src/flct_if.sv
interface flct_req_if
    import flct_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   node_id;

    modport source (output valid, output kind, output node_id, input ready);
    modport sink (input valid, input kind, input node_id, output ready);
endinterface

interface flct_rsp_if
    import flct_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] cursor_node;
    logic            cursor_valid;
    logic            list_empty;
    logic            status;

    modport source (output valid, output cursor_node, output cursor_valid,
                    output list_empty, output status, input ready);
    modport sink (input valid, input cursor_node, input cursor_valid,
                  input list_empty, input status, output ready);
endinterface

### src/flct_ram.sv
module flct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/flct_ctrl.sv
module flct_ctrl
    import flct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_DONE;
                case (sts.kind)
                    KIND_INSERT:
                    begin
                        if (!sts.in_range || sts.id_is_cursor)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_entry = 1'b1;
                            state_next   = ST_INS_RD;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_entry = 1'b1;
                            state_next   = ST_REM_RD;
                        end
                    end
                    KIND_START:
                    begin
                        cmd.cursor_head = 1'b1;
                    end
                    KIND_ADVANCE:
                    begin
                        if (!sts.cursor_node)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_cur_next = 1'b1;
                            state_next      = ST_ADV_RD;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        cmd.clear_ptrs = 1'b1;
                        state_next     = ST_CLR;
                    end
                    default:
                    begin
                        cmd.set_err = 1'b1;
                    end
                endcase
            end
            ST_INS_RD:
            begin
                cmd.latch_entry = 1'b1;
                state_next      = ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                if (sts.head_after_err)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.unlink  = sts.entry_member;
                    cmd.mem_wr  = 1'b1;
                    cmd.mem_val = 1'b1;
                    state_next  = ST_INS_LINK;
                end
            end
            ST_INS_LINK:
            begin
                if (sts.head_node)
                begin
                    cmd.rd_cur_next = 1'b1;
                    state_next      = ST_INS_NRD;
                end
                else
                begin
                    cmd.link_solo = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_INS_NRD:
            begin
                cmd.latch_next = 1'b1;
                state_next     = ST_INS_W1;
            end
            ST_INS_W1:
            begin
                cmd.link_w1 = 1'b1;
                state_next  = ST_INS_W2;
            end
            ST_INS_W2:
            begin
                cmd.link_w2 = 1'b1;
                state_next  = ST_DONE;
            end
            ST_REM_RD:
            begin
                cmd.latch_entry = 1'b1;
                state_next      = ST_REM_CHK;
            end
            ST_REM_CHK:
            begin
                state_next = ST_DONE;
                if (!sts.entry_member)
                begin
                    cmd.set_err = 1'b1;
                end
                else
                begin
                    cmd.unlink  = 1'b1;
                    cmd.mem_wr  = 1'b1;
                    cmd.mem_val = 1'b0;
                end
            end
            ST_ADV_RD:
            begin
                cmd.latch_next = 1'b1;
                state_next     = ST_ADV_MRD;
            end
            ST_ADV_MRD:
            begin
                if (sts.n_node)
                begin
                    cmd.rd_n_member = 1'b1;
                    state_next      = ST_ADV_CHK;
                end
                else
                begin
                    cmd.cursor_none = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_ADV_CHK:
            begin
                state_next = ST_DONE;
                if (!sts.n_member)
                begin
                    cmd.set_err = 1'b1;
                end
                else
                begin
                    cmd.cursor_next = 1'b1;
                end
            end
            ST_CLR:
            begin
                cmd.sweep = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && sts.in_valid) |=> state_reg == ST_CHECK)
        else $error("accepted beat did not move to decode");
`endif

endmodule

### src/flct_dp.sv
module flct_dp
    import flct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    flct_req_if.sink           req,
    flct_rsp_if.source         rsp,
    input  cmd_t               cmd,
    output sts_t               sts
);

    logic [KIND_W-1:0]  kind_reg;
    logic [ID_W-1:0]    id_reg;
    logic [LIMIT_W-1:0] node_limit_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   cursor_reg;
    logic [PTR_W-1:0]   cursor_next;
    logic               m_reg;
    logic [PTR_W-1:0]   p_reg;
    logic [PTR_W-1:0]   n_reg;
    logic               err_reg;
    logic [ID_W-1:0]    cnt_reg;
    logic               out_valid_reg;
    logic [ID_W-1:0]    out_cursor_node_reg;
    logic               out_cursor_valid_reg;
    logic               out_list_empty_reg;
    logic               out_status_reg;

    logic               p_node;
    logic               n_node;
    logic               cnt_last;

    logic               nx_we;
    logic [ID_W-1:0]    nx_waddr;
    logic [PTR_W-1:0]   nx_wdata;
    logic               nx_re;
    logic [ID_W-1:0]    nx_raddr;
    logic [PTR_W-1:0]   nx_rdata;
    logic               pv_we;
    logic [ID_W-1:0]    pv_waddr;
    logic [PTR_W-1:0]   pv_wdata;
    logic               pv_re;
    logic [PTR_W-1:0]   pv_rdata;
    logic               mb_we;
    logic [ID_W-1:0]    mb_waddr;
    logic               mb_wdata;
    logic               mb_re;
    logic [ID_W-1:0]    mb_raddr;
    logic               mb_rdata;

    assign p_node   = is_node(p_reg);
    assign n_node   = is_node(n_reg);
    assign cnt_last = (cnt_reg == LAST_ID);

    flct_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_next_ram (
        .clk     (clk),
        .wr_en   (nx_we),
        .wr_addr (nx_waddr),
        .wr_data (nx_wdata),
        .rd_en   (nx_re),
        .rd_addr (nx_raddr),
        .rd_data (nx_rdata)
    );

    flct_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_prev_ram (
        .clk     (clk),
        .wr_en   (pv_we),
        .wr_addr (pv_waddr),
        .wr_data (pv_wdata),
        .rd_en   (pv_re),
        .rd_addr (id_reg),
        .rd_data (pv_rdata)
    );

    flct_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_member_ram (
        .clk     (clk),
        .wr_en   (mb_we),
        .wr_addr (mb_waddr),
        .wr_data (mb_wdata),
        .rd_en   (mb_re),
        .rd_addr (mb_raddr),
        .rd_data (mb_rdata)
    );

    // Memory port steering
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = id_reg;
        nx_wdata = NONE_PTR;
        if (cmd.unlink && p_node)
        begin
            nx_we    = 1'b1;
            nx_waddr = p_reg[ID_W-1:0];
            nx_wdata = n_reg;
        end
        else if (cmd.link_solo)
        begin
            nx_we = 1'b1;
        end
        else if (cmd.link_w1)
        begin
            nx_we    = 1'b1;
            nx_wdata = n_reg;
        end
        else if (cmd.link_w2)
        begin
            nx_we    = 1'b1;
            nx_waddr = cursor_reg[ID_W-1:0];
            nx_wdata = to_ptr(id_reg);
        end

        pv_we    = 1'b0;
        pv_waddr = id_reg;
        pv_wdata = NONE_PTR;
        if (cmd.unlink && n_node)
        begin
            pv_we    = 1'b1;
            pv_waddr = n_reg[ID_W-1:0];
            pv_wdata = p_reg;
        end
        else if (cmd.link_solo)
        begin
            pv_we = 1'b1;
        end
        else if (cmd.link_w1)
        begin
            pv_we    = 1'b1;
            pv_wdata = cursor_reg;
        end
        else if (cmd.link_w2 && n_node)
        begin
            pv_we    = 1'b1;
            pv_waddr = n_reg[ID_W-1:0];
            pv_wdata = to_ptr(id_reg);
        end

        nx_re    = cmd.rd_entry || cmd.rd_cur_next;
        nx_raddr = cmd.rd_cur_next ? cursor_reg[ID_W-1:0] : id_reg;
        pv_re    = cmd.rd_entry;

        mb_we    = cmd.mem_wr || cmd.sweep;
        mb_waddr = cmd.sweep ? cnt_reg : id_reg;
        mb_wdata = cmd.sweep ? 1'b0 : cmd.mem_val;
        mb_re    = cmd.rd_entry || cmd.rd_n_member;
        mb_raddr = cmd.rd_n_member ? n_reg[ID_W-1:0] : id_reg;
    end

    always_comb
    begin
        head_next = head_reg;
        if (cmd.clear_ptrs)
        begin
            head_next = NONE_PTR;
        end
        else if (cmd.unlink && !p_node)
        begin
            head_next = n_reg;
        end
        else if (cmd.link_solo)
        begin
            head_next = to_ptr(id_reg);
        end

        cursor_next = cursor_reg;
        if (cmd.clear_ptrs || cmd.cursor_none)
        begin
            cursor_next = NONE_PTR;
        end
        else if (cmd.cursor_head)
        begin
            cursor_next = head_reg;
        end
        else if (cmd.cursor_next)
        begin
            cursor_next = n_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_limit_reg <= LIMIT_RESET;
            head_reg       <= NONE_PTR;
            cursor_reg     <= NONE_PTR;
            err_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_limit_reg <= cfg_wr_data;
            end
            head_reg   <= head_next;
            cursor_reg <= cursor_next;
            if (cmd.idle && req.valid)
            begin
                err_reg <= 1'b0;
            end
            else if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.sweep)
            begin
                cnt_reg <= cnt_last ? '0 : cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.idle && req.valid)
        begin
            kind_reg <= req.kind;
            id_reg   <= req.node_id;
        end
        if (cmd.latch_entry)
        begin
            m_reg <= mb_rdata;
            p_reg <= pv_rdata;
            n_reg <= nx_rdata;
        end
        else if (cmd.latch_next)
        begin
            n_reg <= nx_rdata;
        end
        if (cmd.out_load)
        begin
            out_cursor_node_reg  <= is_node(cursor_reg) ? cursor_reg[ID_W-1:0] : '0;
            out_cursor_valid_reg <= is_node(cursor_reg);
            out_list_empty_reg   <= !is_node(head_reg);
            out_status_reg       <= err_reg ? STATUS_REJECT : STATUS_DONE;
        end
    end

    always_comb
    begin
        sts.in_valid       = req.valid;
        sts.kind           = kind_t'(kind_reg);
        sts.in_range       = (CMP_W'(id_reg) < CMP_W'(node_limit_reg))
                             && (to_ptr(id_reg) < NONE_PTR);
        sts.id_is_cursor   = (cursor_reg == to_ptr(id_reg));
        sts.cursor_node    = is_node(cursor_reg);
        sts.head_node      = is_node(head_reg);
        // Set when the head would still be a node once the node is unlinked and no cursor is set
        sts.head_after_err = ((m_reg && !p_node) ? n_node : is_node(head_reg))
                             && !is_node(cursor_reg);
        sts.entry_member   = m_reg;
        sts.n_node         = n_node;
        sts.n_member       = mb_rdata;
        sts.cnt_last       = cnt_last;
        sts.out_free       = !out_valid_reg || rsp.ready;
    end

    assign req.ready        = cmd.idle;
    assign rsp.valid        = out_valid_reg;
    assign rsp.cursor_node  = out_cursor_node_reg;
    assign rsp.cursor_valid = out_cursor_valid_reg;
    assign rsp.list_empty   = out_list_empty_reg;
    assign rsp.status       = out_status_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp.ready))
        else $error("pending result beat overwritten");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_err |=> ($stable(head_reg) && $stable(cursor_reg)))
        else $error("rejected item changed head or cursor");

    a_member_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep && cmd.mem_wr))
        else $error("membership write collides with clearing sweep");
`endif

endmodule

### src/fringe_list_cursor_linked_table.sv
// Channel  | Dir | Payload                                          | Beat taken when
// req      | in  | kind, node_id                                    | valid && ready
// rsp      | out | cursor_node, cursor_valid, list_empty, status    | valid && ready
// cfg      | in  | cfg_wr_data (node_limit)                         | cfg_wr_en
//
// One item at a time; req.ready is high only while idle, so a new beat is taken only after
// the previous result has been loaded into the result register.
// The link memories have one read and one write port each.
// After reset, a sweep zeroes the membership memory; req.ready stays low.
// Clear runs the same sweep. A held result stalls only the finishing item.
module fringe_list_cursor_linked_table
    import flct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    flct_req_if.sink           req,
    flct_rsp_if.source         rsp
);

    cmd_t cmd;
    sts_t sts;

    flct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    flct_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

### tb/list_checker.sv
module list_checker
    import flct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    flct_req_if                req,
    flct_rsp_if                rsp,
    output int                 fail_count,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0] cursor_node;
        logic            cursor_valid;
        logic            list_empty;
        logic            status;
    } cursor_report_t;

    // Mirror of the link memories and pointers
    logic [PTR_W-1:0]   nxt_tab [MAX_NODES];
    logic [PTR_W-1:0]   prv_tab [MAX_NODES];
    logic               member  [MAX_NODES];
    logic [PTR_W-1:0]   head_p;
    logic [PTR_W-1:0]   cur_p;
    logic [LIMIT_W-1:0] limit_reg;

    cursor_report_t cursor_reports_q [$];
    int fails = 0;
    int waiting = 0;

    assign fail_count  = fails;
    assign outstanding = waiting;

    function automatic logic holds_node(input logic [PTR_W-1:0] p);
        return p < NONE_PTR;
    endfunction

    function automatic void wipe_list();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            member[i] = 1'b0;
        end
        head_p = NONE_PTR;
        cur_p  = NONE_PTR;
    endfunction

    function automatic void drop_node(input logic [ID_W-1:0] id);
        logic [PTR_W-1:0] p;
        logic [PTR_W-1:0] n;
        p = prv_tab[id];
        n = nxt_tab[id];
        if (holds_node(p))
            nxt_tab[p[ID_W-1:0]] = n;
        else
            head_p = n;
        if (holds_node(n))
            prv_tab[n[ID_W-1:0]] = p;
        member[id] = 1'b0;
    endfunction

    function automatic cursor_report_t step_list(input logic [KIND_W-1:0] code,
                                                 input logic [ID_W-1:0] id);
        cursor_report_t   res;
        int               lim_eff;
        logic             in_range;
        logic             reject;
        logic [PTR_W-1:0] idp;
        logic [PTR_W-1:0] head_after;
        logic [PTR_W-1:0] c;
        logic [PTR_W-1:0] n;
        lim_eff  = (int'(limit_reg) < MAX_NODES) ? int'(limit_reg) : MAX_NODES;
        idp      = PTR_W'(id);
        in_range = int'(id) < lim_eff;
        reject   = 1'b0;
        case (code)
            KIND_INSERT:
            begin
                if (!in_range || idp == cur_p)
                    reject = 1'b1;
                else
                begin
                    // the list may become empty once the node is taken out
                    head_after = head_p;
                    if (member[id] && !holds_node(prv_tab[id]))
                        head_after = nxt_tab[id];
                    if (holds_node(head_after) && !holds_node(cur_p))
                        reject = 1'b1;
                    else
                    begin
                        if (member[id])
                            drop_node(id);
                        member[id] = 1'b1;
                        if (holds_node(head_p))
                        begin
                            c = cur_p;
                            n = nxt_tab[c[ID_W-1:0]];
                            prv_tab[id] = c;
                            nxt_tab[id] = n;
                            if (holds_node(n))
                                prv_tab[n[ID_W-1:0]] = idp;
                            nxt_tab[c[ID_W-1:0]] = idp;
                        end
                        else
                        begin
                            head_p      = idp;
                            prv_tab[id] = NONE_PTR;
                            nxt_tab[id] = NONE_PTR;
                        end
                    end
                end
            end
            KIND_REMOVE:
            begin
                if (!in_range || !member[id])
                    reject = 1'b1;
                else
                    drop_node(id);
            end
            KIND_START:
                cur_p = head_p;
            KIND_ADVANCE:
            begin
                if (!holds_node(cur_p))
                    reject = 1'b1;
                else
                begin
                    n = nxt_tab[cur_p[ID_W-1:0]];
                    // a removed cursor may point on to a node that has gone too
                    if (holds_node(n) && !member[n[ID_W-1:0]])
                        reject = 1'b1;
                    else
                        cur_p = holds_node(n) ? n : NONE_PTR;
                end
            end
            KIND_CLEAR:
                wipe_list();
            default:
                reject = 1'b1;
        endcase
        res.cursor_valid = holds_node(cur_p);
        res.cursor_node  = holds_node(cur_p) ? cur_p[ID_W-1:0] : '0;
        res.list_empty   = !holds_node(head_p);
        res.status       = reject ? STATUS_REJECT : STATUS_DONE;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t list_checker: %s got %0d want %0d", $realtime, what, got, want);
        fails++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t want;
        if (!rst_n)
        begin
            wipe_list();
            limit_reg = LIMIT_RESET;
            cursor_reports_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
            // compare before taking a new beat, so a stray result never meets its own item
            if (rsp.valid && rsp.ready)
            begin
                if (cursor_reports_q.size() == 0)
                    report_mismatch("result beat with nothing pending, cursor_node",
                                    rsp.cursor_node, 0);
                else
                begin
                    want = cursor_reports_q.pop_front();
                    check_field("cursor_node", rsp.cursor_node, want.cursor_node);
                    check_field("cursor_valid", rsp.cursor_valid, want.cursor_valid);
                    check_field("list_empty", rsp.list_empty, want.list_empty);
                    check_field("status", rsp.status, want.status);
                end
            end
            if (req.valid && req.ready)
                cursor_reports_q.push_back(step_list(req.kind, req.node_id));
        end
        waiting = cursor_reports_q.size();
    end

endmodule

### tb/tb.sv
module tb
    import flct_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ITEMS    = 80;
    localparam int SETTLE_CYCLES  = 20;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    int                 fail_count;
    int                 outstanding;
    int                 cycle_count = 0;
    int                 burst_left = 0;

    flct_req_if req_ch ();
    flct_rsp_if rsp_ch ();

    fringe_list_cursor_linked_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    list_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: stretches of steady accept, random stalls and long holds
    initial
    begin
        int mode;
        int stretch;
        mode    = 0;
        stretch = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 2);
                stretch = $urandom_range(5, 60);
            end
            stretch--;
            case (mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                default: rsp_ch.ready <= (stretch % 10 == 0);
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_beat(input logic [KIND_W-1:0] code, input logic [ID_W-1:0] id);
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= code;
        req_ch.node_id <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic hold_off(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic issue(input logic [KIND_W-1:0] code, input logic [ID_W-1:0] id);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
                hold_off(gap);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_beat(code, id);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id(input int lim_eff, input int base,
                                                input int span);
        int r;
        int b;
        r = $urandom_range(0, 99);
        if (r < 80)
            return ID_W'(base + $urandom_range(0, span - 1));
        if (r < 90)
            return ID_W'($urandom_range(0, int'(LAST_ID)));
        if (r < 96)
        begin
            // land on either side of the limit
            b = (lim_eff > int'(LAST_ID)) ? int'(LAST_ID) : lim_eff;
            case ($urandom_range(0, 2))
                0:       return ID_W'((b > 0) ? b - 1 : 0);
                1:       return ID_W'(b);
                default: return LAST_ID;
            endcase
        end
        return '0;
    endfunction

    task automatic random_op(input int lim_eff, input int base, input int span);
        int                r;
        logic [KIND_W-1:0] code;
        r = $urandom_range(0, 199);
        if (r < 70)
            code = KIND_INSERT;
        else if (r < 110)
            code = KIND_REMOVE;
        else if (r < 135)
            code = KIND_START;
        else if (r < 190)
            code = KIND_ADVANCE;
        else if (r < 193)
            code = KIND_CLEAR;
        else
            code = KIND_W'($urandom_range(int'(KIND_CLEAR) + 1, (1 << KIND_W) - 1));
        issue(code, pick_id(lim_eff, base, span));
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] limits [8];
        int                 lim_eff;
        int                 base;
        int                 span;
        limits = '{LIMIT_W'(1024), LIMIT_W'(2047), LIMIT_W'(0), LIMIT_W'(1),
                   LIMIT_W'(2), LIMIT_W'(300), LIMIT_W'(17), LIMIT_W'(1024)};
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_ch.valid   = 1'b0;
        req_ch.kind    = KIND_START;
        req_ch.node_id = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_limit(LIMIT_RESET);
        // Directed walk through the corner cases
        issue(KIND_ADVANCE, 10'd0);      // no cursor
        issue(KIND_INSERT, 10'd0);       // empty list takes the head
        issue(KIND_INSERT, 10'd5);       // non-empty, no cursor
        issue(KIND_START, LAST_ID);
        issue(KIND_INSERT, 10'd0);       // the cursor node itself
        issue(KIND_INSERT, LAST_ID);
        issue(KIND_INSERT, 10'd5);
        issue(KIND_INSERT, LAST_ID);     // member: unlink, then relink
        issue(KIND_REMOVE, 10'd7);       // not a member
        issue(KIND_ADVANCE, 10'd0);
        issue(KIND_REMOVE, LAST_ID);     // cursor stays on a removed node
        issue(KIND_ADVANCE, 10'd0);      // follow the kept link
        issue(KIND_REMOVE, 10'd0);       // head goes
        issue(KIND_START, 10'd0);
        issue(KIND_REMOVE, 10'd5);       // list empties, cursor left dangling
        issue(KIND_INSERT, 10'd3);
        issue(KIND_ADVANCE, 10'd0);      // off the end
        issue(KIND_INSERT, 10'd3);       // sole member, no cursor: allowed
        issue(KIND_START, 10'd0);
        issue(KIND_INSERT, 10'd9);
        issue(KIND_REMOVE, 10'd3);
        issue(KIND_REMOVE, 10'd9);
        issue(KIND_ADVANCE, 10'd0);      // next link names a non-member
        issue(KIND_W'((1 << KIND_W) - 1), 10'h2AA);
        issue(KIND_CLEAR, 10'h155);

        for (int p = 0; p < $size(limits); p++)
        begin
            set_limit(limits[p]);
            lim_eff = (int'(limits[p]) > MAX_NODES) ? MAX_NODES : int'(limits[p]);
            span    = (lim_eff >= 16) ? 16 : ((lim_eff < 1) ? 4 : lim_eff);
            if (p == 0)
                base = MAX_NODES - 16;
            else if (lim_eff > 32)
                base = $urandom_range(0, lim_eff - 16);
            else
                base = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_op(lim_eff, base, span);
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### files.f
src/flct_pkg.sv
src/flct_if.sv
src/flct_ram.sv
src/flct_ctrl.sv
src/flct_dp.sv
src/fringe_list_cursor_linked_table.sv
tb/list_checker.sv
tb/tb.sv
